FILE: rtl/wsa_pkg.sv
// wsa_pkg: shared types, codes and constants of the window segment allocator
// no dependencies; imported by every rtl module of the block
package wsa_pkg;

    localparam int INDEX_MAX_DEF = 63;
    localparam int WIN_SHIFT_DEF = 24;

    localparam int CMD_W   = 2;
    localparam int SIZE_W  = 33;
    localparam int ID_W    = 32;
    localparam int ADDR_W  = 64;
    localparam int STS_W   = 2;
    localparam int WNUM_W  = 8;
    localparam int CFGI_W  = 2;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 232;

    localparam logic [SIZE_W-1:0] WIN_LIMIT   = 33'h1_0000_0000;
    localparam logic [31:0]       FIRST_INDEX = 32'h0000_0001;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT    = 2'd0,
        CMD_CREATE  = 2'd1,
        CMD_DESTROY = 2'd2,
        CMD_LOOKUP  = 2'd3
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NO_ROOM   = 2'd1,
        STS_NO_INDEX  = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [CFGI_W-1:0] {
        CFG_WIN_NUM   = 2'd0,
        CFG_WIN_SIZE  = 2'd1,
        CFG_BASE_RIO  = 2'd2,
        CFG_BASE_PHYS = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_BOOT,
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_CR_DEC,
        ST_SH_UP,
        ST_WR_REM,
        ST_WR_BEST,
        ST_DS_DEC,
        ST_SH_DN,
        ST_WR_MRG,
        ST_EMIT,
        ST_ERR
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_INIT,
        DP_SCAN,
        DP_CR_SETUP,
        DP_SH_UP,
        DP_WR_REM,
        DP_WR_BEST,
        DP_DS_SETUP,
        DP_SH_DN,
        DP_WR_MRG,
        DP_EMIT,
        DP_ERR
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic best_ok;
        logic rest_nz;
        logic idx_ok;
        logic found;
        logic owner_ok;
        logic up_done;
        logic dn_done;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/wsa_dp.sv
// wsa_dp: segment table memory, index free map, scan and move datapath, result register
// depends on wsa_pkg; driven by wsa_ctrl through t_dp_cmd
module wsa_dp #(
    parameter int NSLOT     = wsa_pkg::INDEX_MAX_DEF + 1,
    parameter int WIN_SHIFT = wsa_pkg::WIN_SHIFT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wsa_pkg::t_dp_cmd                  i_cmd,
    output wsa_pkg::t_dp_sts                  o_sts,
    input  logic [wsa_pkg::IN_DATA_W-1:0]     i_s_data,
    input  logic                              i_cfg_we,
    input  logic [wsa_pkg::CFGI_W-1:0]        i_cfg_index,
    input  logic [wsa_pkg::ADDR_W-1:0]        i_cfg_wdata,
    output logic                              o_m_valid,
    input  logic                              i_m_ready,
    output logic [wsa_pkg::OUT_DATA_W-1:0]    o_m_data,
    output logic [wsa_pkg::STS_W-1:0]         o_m_kind
);
    import wsa_pkg::*;

    localparam int IW = $clog2(NSLOT);
    localparam int CW = $clog2(NSLOT + 1);

    typedef struct packed {
        logic [SIZE_W-1:0] off;
        logic [SIZE_W-1:0] len;
        logic              used;
        logic [ID_W-1:0]   owner;
        logic [IW-1:0]     idx;
    } t_ent;

    t_ent mem [NSLOT];

    logic [SIZE_W-1:0] r_req;
    logic [ID_W-1:0]   r_owner;
    logic [ID_W-1:0]   r_sid;

    logic [WNUM_W-1:0] r_wn;
    logic [SIZE_W-1:0] r_ws;
    logic [ADDR_W-1:0] r_brio;
    logic [ADDR_W-1:0] r_bphys;

    logic [CW-1:0]     r_count;
    logic [NSLOT-1:0]  r_map;
    logic [CW-1:0]     r_ptr;
    t_ent              r_rd;
    logic [IW-1:0]     r_rd_pos;
    logic              r_rd_v;
    t_ent              r_best;
    logic [IW-1:0]     r_best_pos;
    logic              r_bv;
    logic [IW-1:0]     r_fidx;
    logic              r_got;
    t_ent              r_hit;
    logic [IW-1:0]     r_hit_pos;
    logic              r_found;
    t_ent              r_prv;
    t_ent              r_hprv;
    t_ent              r_nxt;
    logic              r_nxt_v;
    t_ent              r_emit;
    logic [IW-1:0]     r_s;
    logic [1:0]        r_k;

    logic                  r_ov;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [STS_W-1:0]      r_okind;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    t_ent              wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;

    logic [SIZE_W-1:0] rest;
    logic [CW-1:0]     ins;
    logic              pf;
    logic              nf;
    logic [SIZE_W-1:0] mrg_len;
    logic [IW-1:0]     s_pos;
    logic [1:0]        k_cnt;
    logic [SIZE_W-1:0] ws_clamp;
    t_ent              init_ent;
    logic              rd_match;
    logic              rd_fit;
    logic              out_free;

    function automatic logic [ID_W-1:0] mk_id(input logic [WNUM_W-1:0] wn,
                                              input logic [IW-1:0] idx);
        mk_id = (ID_W'(wn) << WIN_SHIFT) | ID_W'(idx);
    endfunction

    assign out_free = !r_ov || i_m_ready;
    assign rest     = r_best.len - r_req;
    assign ins      = CW'(r_best_pos) + CW'(1);
    assign pf       = (r_hit_pos != '0) && !r_hprv.used;
    assign nf       = r_nxt_v && !r_nxt.used;
    assign mrg_len  = (pf ? r_hprv.len : '0) + r_hit.len + (nf ? r_nxt.len : '0);
    assign s_pos    = pf ? r_hit_pos - IW'(1) : r_hit_pos;
    assign k_cnt    = {1'b0, pf} + {1'b0, nf};
    assign ws_clamp = r_ws[SIZE_W-1] ? WIN_LIMIT : r_ws;
    assign rd_match = mk_id(r_wn, r_rd.idx) == r_sid;
    assign rd_fit   = !r_rd.used && (r_rd.len >= r_req) && (!r_bv || (r_rd.len < r_best.len));

    always_comb begin
        init_ent       = '0;
        init_ent.len   = ws_clamp;
        init_ent.idx   = IW'(FIRST_INDEX);
    end

    always_comb begin
        o_sts.scan_done = (r_ptr == CW'(NSLOT)) && !r_rd_v;
        o_sts.best_ok   = r_bv;
        o_sts.rest_nz   = rest != '0;
        o_sts.idx_ok    = r_got && (r_count < CW'(NSLOT));
        o_sts.found     = r_found;
        o_sts.owner_ok  = r_hit.owner == r_owner;
        o_sts.up_done   = (r_ptr == ins) && !r_rd_v;
        o_sts.dn_done   = (r_ptr >= r_count) && !r_rd_v;
        o_sts.out_free  = out_free;
    end

    // memory port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rd;
        rd_en   = 1'b0;
        rd_addr = r_ptr[IW-1:0];
        case (i_cmd.op)
            DP_INIT: begin
                wr_en   = 1'b1;
                wr_data = init_ent;
            end
            DP_SCAN: begin
                rd_en = r_ptr < CW'(NSLOT);
            end
            DP_SH_UP: begin
                rd_en   = r_ptr > ins;
                rd_addr = IW'(r_ptr - CW'(1));
                wr_en   = r_rd_v;
                wr_addr = r_rd_pos + IW'(1);
            end
            DP_SH_DN: begin
                rd_en   = r_ptr < r_count;
                wr_en   = r_rd_v;
                wr_addr = r_rd_pos - IW'(r_k);
            end
            DP_WR_REM: begin
                wr_en         = 1'b1;
                wr_addr       = ins[IW-1:0];
                wr_data       = '0;
                wr_data.off   = r_best.off + r_req;
                wr_data.len   = rest;
                wr_data.idx   = r_fidx;
            end
            DP_WR_BEST: begin
                wr_en   = 1'b1;
                wr_addr = r_best_pos;
                wr_data = r_emit;
            end
            DP_WR_MRG: begin
                wr_en   = 1'b1;
                wr_addr = r_s;
                wr_data = r_emit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd     <= mem[rd_addr];
            r_rd_pos <= rd_addr;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wn    <= '0;
            r_ws    <= WIN_LIMIT;
            r_brio  <= '0;
            r_bphys <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_WIN_NUM:   r_wn    <= i_cfg_wdata[WNUM_W-1:0];
                CFG_WIN_SIZE:  r_ws    <= i_cfg_wdata[SIZE_W-1:0];
                CFG_BASE_RIO:  r_brio  <= i_cfg_wdata;
                CFG_BASE_PHYS: r_bphys <= i_cfg_wdata;
            endcase
        end
    end

    // table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_map   <= '0;
            r_ptr   <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_LATCH: begin
                    r_ptr  <= '0;
                    r_rd_v <= 1'b0;
                end
                DP_INIT: begin
                    r_count <= CW'(1);
                    r_map   <= {{(NSLOT-2){1'b1}}, 2'b00};
                end
                DP_SCAN: begin
                    if (r_ptr < CW'(NSLOT)) begin
                        r_rd_v <= r_ptr < r_count;
                        r_ptr  <= r_ptr + CW'(1);
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                end
                DP_CR_SETUP: begin
                    r_ptr  <= r_count;
                    r_rd_v <= 1'b0;
                end
                DP_SH_UP: begin
                    if (r_ptr > ins) begin
                        r_rd_v <= 1'b1;
                        r_ptr  <= r_ptr - CW'(1);
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                end
                DP_WR_REM: begin
                    r_count        <= r_count + CW'(1);
                    r_map[r_fidx]  <= 1'b0;
                end
                DP_DS_SETUP: begin
                    r_ptr  <= CW'(s_pos) + CW'(1) + CW'(k_cnt);
                    r_rd_v <= 1'b0;
                    if (nf) begin
                        r_map[r_nxt.idx] <= 1'b1;
                    end
                    if (pf) begin
                        r_map[r_hit.idx] <= 1'b1;
                    end
                end
                DP_SH_DN: begin
                    if (r_ptr < r_count) begin
                        r_rd_v <= 1'b1;
                        r_ptr  <= r_ptr + CW'(1);
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                end
                DP_WR_MRG: begin
                    r_count <= r_count - CW'(r_k);
                end
                default: begin
                end
            endcase
        end
    end

    // scan results and working entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv    <= 1'b0;
            r_got   <= 1'b0;
            r_found <= 1'b0;
            r_nxt_v <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_LATCH: begin
                    r_req   <= i_s_data[SIZE_W-1:0];
                    r_owner <= i_s_data[SIZE_W+ID_W-1:SIZE_W];
                    r_sid   <= i_s_data[SIZE_W+2*ID_W-1:SIZE_W+ID_W];
                    r_bv    <= 1'b0;
                    r_got   <= 1'b0;
                    r_found <= 1'b0;
                    r_nxt_v <= 1'b0;
                end
                DP_INIT: begin
                    r_emit <= init_ent;
                end
                DP_SCAN: begin
                    if (r_ptr < CW'(NSLOT) && !r_got && r_map[r_ptr[IW-1:0]]) begin
                        r_got  <= 1'b1;
                        r_fidx <= r_ptr[IW-1:0];
                    end
                    if (r_rd_v) begin
                        r_prv <= r_rd;
                        if (rd_fit) begin
                            r_bv       <= 1'b1;
                            r_best     <= r_rd;
                            r_best_pos <= r_rd_pos;
                        end
                        if (!r_found && rd_match) begin
                            r_found   <= 1'b1;
                            r_hit     <= r_rd;
                            r_emit    <= r_rd;
                            r_hit_pos <= r_rd_pos;
                            r_hprv    <= r_prv;
                        end else if (r_found && !r_nxt_v) begin
                            r_nxt_v <= 1'b1;
                            r_nxt   <= r_rd;
                        end
                    end
                end
                DP_CR_SETUP: begin
                    r_emit <= '{off: r_best.off, len: r_req, used: 1'b1,
                                owner: r_owner, idx: r_best.idx};
                end
                DP_DS_SETUP: begin
                    r_s    <= s_pos;
                    r_k    <= k_cnt;
                    r_emit <= '{off: (pf ? r_hprv.off : r_hit.off), len: mrg_len,
                                used: 1'b0, owner: '0,
                                idx: (pf ? r_hprv.idx : r_hit.idx)};
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == DP_EMIT || i_cmd.op == DP_ERR) begin
            r_ov <= 1'b1;
        end else if (i_m_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_EMIT) begin
            r_okind <= STS_OK;
            r_odata <= {6'd0, r_emit.used, r_emit.owner, r_emit.len,
                        r_bphys + ADDR_W'(r_emit.off), r_brio + ADDR_W'(r_emit.off),
                        mk_id(r_wn, r_emit.idx)};
        end else if (i_cmd.op == DP_ERR) begin
            r_okind <= i_cmd.code;
            r_odata <= '0;
        end
    end

    assign o_m_valid = r_ov;
    assign o_m_data  = r_odata;
    assign o_m_kind  = r_okind;

endmodule

FILE: rtl/wsa_ctrl.sv
// wsa_ctrl: command sequencer of the window segment allocator
// depends on wsa_pkg; drives wsa_dp through t_dp_cmd and reads t_dp_sts
module wsa_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_valid,
    output logic                       o_s_ready,
    input  logic [wsa_pkg::CMD_W-1:0]  i_s_kind,
    input  wsa_pkg::t_dp_sts           i_sts,
    output wsa_pkg::t_dp_cmd           o_cmd
);
    import wsa_pkg::*;

    t_state  r_state, n_state;
    t_cmd    r_kind, n_kind;
    t_status r_err, n_err;
    logic    accept;

    assign accept = (r_state == ST_IDLE) && i_s_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BOOT;
            r_kind  <= CMD_INIT;
            r_err   <= STS_OK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_err   <= n_err;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_err   = r_err;
        unique case (r_state)
            ST_BOOT: n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    n_kind  = t_cmd'(i_s_kind);
                    n_state = (t_cmd'(i_s_kind) == CMD_INIT) ? ST_INIT : ST_SCAN;
                end
            end
            ST_INIT: n_state = ST_EMIT;
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    unique case (r_kind)
                        CMD_CREATE:  n_state = ST_CR_DEC;
                        CMD_DESTROY: n_state = ST_DS_DEC;
                        CMD_LOOKUP: begin
                            if (i_sts.found) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_state = ST_ERR;
                                n_err   = STS_NOT_FOUND;
                            end
                        end
                        CMD_INIT: n_state = ST_INIT;
                    endcase
                end
            end
            ST_CR_DEC: begin
                if (!i_sts.best_ok) begin
                    n_state = ST_ERR;
                    n_err   = STS_NO_ROOM;
                end else if (!i_sts.rest_nz) begin
                    n_state = ST_WR_BEST;
                end else if (i_sts.idx_ok) begin
                    n_state = ST_SH_UP;
                end else begin
                    n_state = ST_ERR;
                    n_err   = STS_NO_INDEX;
                end
            end
            ST_SH_UP:   if (i_sts.up_done) n_state = ST_WR_REM;
            ST_WR_REM:  n_state = ST_WR_BEST;
            ST_WR_BEST: n_state = ST_EMIT;
            ST_DS_DEC: begin
                if (i_sts.found && i_sts.owner_ok) begin
                    n_state = ST_SH_DN;
                end else begin
                    n_state = ST_ERR;
                    n_err   = STS_NOT_FOUND;
                end
            end
            ST_SH_DN:  if (i_sts.dn_done) n_state = ST_WR_MRG;
            ST_WR_MRG: n_state = ST_EMIT;
            ST_EMIT:   if (i_sts.out_free) n_state = ST_IDLE;
            ST_ERR:    if (i_sts.out_free) n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op   = DP_NOP;
        o_cmd.code = r_err;
        o_s_ready  = 1'b0;
        unique case (r_state)
            ST_BOOT:    o_cmd.op = DP_INIT;
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (accept) o_cmd.op = DP_LATCH;
            end
            ST_INIT:    o_cmd.op = DP_INIT;
            ST_SCAN:    o_cmd.op = DP_SCAN;
            ST_CR_DEC:  o_cmd.op = DP_CR_SETUP;
            ST_SH_UP:   o_cmd.op = DP_SH_UP;
            ST_WR_REM:  o_cmd.op = DP_WR_REM;
            ST_WR_BEST: o_cmd.op = DP_WR_BEST;
            ST_DS_DEC: begin
                if (i_sts.found && i_sts.owner_ok) o_cmd.op = DP_DS_SETUP;
            end
            ST_SH_DN:   o_cmd.op = DP_SH_DN;
            ST_WR_MRG:  o_cmd.op = DP_WR_MRG;
            ST_EMIT:    if (i_sts.out_free) o_cmd.op = DP_EMIT;
            ST_ERR:     if (i_sts.out_free) o_cmd.op = DP_ERR;
        endcase
    end

endmodule

FILE: rtl/window_segment_allocator.sv
// window_segment_allocator: top level, best fit segment allocator for one address window
// depends on wsa_pkg, wsa_ctrl and wsa_dp
//
// Commands arrive as words on the s_axis channel: tuser carries the command
// (init, create, destroy, lookup), tdata carries req_size, owner_id, space_id.
// Every command gives exactly one result word on m_axis: tuser is the status,
// tdata describes the segment (all zero when the status is not ok).
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_wdata
// while the block is idle; a new window size applies at the next init.
// One command is worked on at a time. Lookup, create and destroy first scan
// the segment table memory, one entry per cycle over all NSLOT slots. Create
// with a remainder then shifts the entries behind the split one up, one per
// cycle, and destroy with merging shifts the entries behind it down; the table
// has a single read and write port. After reset the block builds the initial
// table (one free segment, index 1) in its boot state before it takes its
// first word. The result sits in an output register: while the receiver
// stalls the next command is still accepted and worked on, and waits only to
// hand over its own result.
module window_segment_allocator #(
    parameter int INDEX_MAX = wsa_pkg::INDEX_MAX_DEF,
    parameter int WIN_SHIFT = wsa_pkg::WIN_SHIFT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_size[32:0], owner_id[64:33], space_id[96:65], zero fill
    input  logic [wsa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command[1:0]
    input  logic [wsa_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_id[31:0], rio_address[95:32], phys_address[159:96],
    // seg_size[192:160], seg_owner[224:193], seg_used[225], zero fill
    output logic [wsa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [wsa_pkg::STS_W-1:0]         m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [wsa_pkg::CFGI_W-1:0]        i_cfg_index,
    input  logic [wsa_pkg::ADDR_W-1:0]        i_cfg_wdata
);
    import wsa_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    wsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_kind  (s_axis_tuser),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    wsa_dp #(
        .NSLOT     (INDEX_MAX + 1),
        .WIN_SHIFT (WIN_SHIFT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_s_data    (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_kind    (m_axis_tuser)
    );

endmodule

FILE: rtl/wsa_checker.sv
// wsa_checker: port level assertions for window_segment_allocator, bound to the top level
// depends on wsa_pkg and window_segment_allocator
module wsa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [wsa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [wsa_pkg::STS_W-1:0]         m_axis_tuser
);
    import wsa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STS_OK) |-> m_axis_tdata == '0)
        else $error("failed command carries segment data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while a command is in work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("channels active straight after reset");

endmodule

bind window_segment_allocator wsa_checker u_wsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
